/* rtl/pgn_pkg.sv */
package pgn_pkg;

    localparam int LATTICE_ENTRIES = 16;
    localparam int LAT_BITS        = $clog2(LATTICE_ENTRIES);
    localparam int GRADIENT_BITS   = 8;
    localparam int GRAD_W          = 8;
    localparam logic [GRAD_W-1:0] GRAD_MASK = GRAD_W'(8'hFF << (GRAD_W - GRADIENT_BITS));

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_DATA_W-1:0] PERM_RESET = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERM  = 3'd0,
        CFG_GX_LO = 3'd1,
        CFG_GX_HI = 3'd2,
        CFG_GY_LO = 3'd3,
        CFG_GY_HI = 3'd4
    } t_cfg_index;

    localparam int SAMPLE_W    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NOISE_W     = 16;
    localparam int OUT_SHIFT   = 9;
    localparam int FADE_C6     = 6;
    localparam int FADE_C15    = 15;
    localparam int FADE_C10    = 10;
    localparam int NUM_CORNERS = 4;

    localparam int PIPE_STAGES = 10;
    localparam int OUT_DEPTH   = 16;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam int INFL_W      = $clog2(PIPE_STAGES + 1);

    typedef struct packed {
        logic [FRAC_BITS-1:0]                   fx;
        logic [FRAC_BITS-1:0]                   fy;
        logic [NUM_CORNERS-1:0][GRAD_W-1:0]     gx;
        logic [NUM_CORNERS-1:0][GRAD_W-1:0]     gy;
    } t_corner_item;

    typedef struct packed {
        logic              issue;
        logic              retire;
        logic [INFL_W-1:0] inflight;
    } t_back_status;

    function automatic logic [LAT_BITS-1:0] perm_at(input logic [CFG_DATA_W-1:0] perm,
                                                    input logic [LAT_BITS-1:0] idx);
        return perm[{idx, 2'b00} +: LAT_BITS];
    endfunction

    function automatic logic [GRAD_W-1:0] grad_at(input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi,
                                                  input logic [LAT_BITS-1:0] idx);
        logic [CFG_DATA_W-1:0] word;
        word = idx[LAT_BITS-1] ? hi : lo;
        return word[{idx[LAT_BITS-2:0], 3'b000} +: GRAD_W] & GRAD_MASK;
    endfunction

endpackage

/* rtl/pgn_queue.sv */
module pgn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/pgn_front.sv */
module pgn_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pgn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pgn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic signed [pgn_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [pgn_pkg::SAMPLE_W-1:0] i_sample_y,
    output pgn_pkg::t_corner_item            o_item
);
    import pgn_pkg::*;

    logic [CFG_DATA_W-1:0] r_perm;
    logic [CFG_DATA_W-1:0] r_gx_lo, r_gx_hi, r_gy_lo, r_gy_hi;

    logic [LAT_BITS-1:0] cx0, cx1, cy0, cy1, hy0, hy1;
    logic [LAT_BITS-1:0] hash [NUM_CORNERS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm  <= PERM_RESET;
            r_gx_lo <= '0;
            r_gx_hi <= '0;
            r_gy_lo <= '0;
            r_gy_hi <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERM:  r_perm  <= i_cfg_data;
                CFG_GX_LO: r_gx_lo <= i_cfg_data;
                CFG_GX_HI: r_gx_hi <= i_cfg_data;
                CFG_GY_LO: r_gy_lo <= i_cfg_data;
                CFG_GY_HI: r_gy_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lattice cells wrap by floor modulo, which is the low bits
    assign cx0 = i_sample_x[FRAC_BITS +: LAT_BITS];
    assign cy0 = i_sample_y[FRAC_BITS +: LAT_BITS];
    assign cx1 = cx0 + LAT_BITS'(1);
    assign cy1 = cy0 + LAT_BITS'(1);
    assign hy0 = perm_at(r_perm, cy0);
    assign hy1 = perm_at(r_perm, cy1);

    // corner order: 00, 10, 01, 11
    assign hash[0] = perm_at(r_perm, cx0 + hy0);
    assign hash[1] = perm_at(r_perm, cx1 + hy0);
    assign hash[2] = perm_at(r_perm, cx0 + hy1);
    assign hash[3] = perm_at(r_perm, cx1 + hy1);

    always_comb begin
        o_item.fx = i_sample_x[FRAC_BITS-1:0];
        o_item.fy = i_sample_y[FRAC_BITS-1:0];
        for (int k = 0; k < NUM_CORNERS; k++) begin
            o_item.gx[k] = grad_at(r_gx_lo, r_gx_hi, hash[k]);
            o_item.gy[k] = grad_at(r_gy_lo, r_gy_hi, hash[k]);
        end
    end

endmodule

/* rtl/pgn_back.sv */
module pgn_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pgn_pkg::t_corner_item            i_item,
    input  logic                             i_item_empty,
    output logic                             o_item_pop,
    input  logic [pgn_pkg::OUT_CNT_W-1:0]    i_out_count,
    output logic                             o_out_push,
    output logic [pgn_pkg::NOISE_W-1:0]      o_noise,
    output pgn_pkg::t_back_status            o_status
);
    import pgn_pkg::*;

    localparam int RX_W   = FRAC_BITS + 1;
    localparam int PROD_W = GRAD_W + RX_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int DIFF_W = DOT_W + 1;
    localparam int T2_W   = 2 * FRAC_BITS;
    localparam int SEED_W = T2_W + 5;
    localparam int F0_W   = 20;
    localparam int F1_W   = 18;
    localparam int FU_W   = FRAC_BITS + 1;
    localparam int M3_W   = F0_W + FRAC_BITS;
    localparam int M4_W   = F1_W + FRAC_BITS;
    localparam int NX_W   = DIFF_W;
    localparam int DY_W   = NX_W + 1;
    localparam int LX_W   = DIFF_W + FU_W + 1;
    localparam int LY_W   = DY_W + FU_W + 1;
    localparam int R_W    = NX_W - OUT_SHIFT;
    localparam int SUM_W  = OUT_CNT_W + 1;

    function automatic logic [F0_W-1:0] fade_seed(input logic [T2_W-1:0] t2,
                                                  input logic [FRAC_BITS-1:0] t);
        logic [SEED_W-1:0] a, b, p;
        a = SEED_W'(t2) * SEED_W'(FADE_C6) + (SEED_W'(FADE_C10) << T2_W);
        b = (SEED_W'(t) * SEED_W'(FADE_C15)) << FRAC_BITS;
        p = a - b;
        return p[FRAC_BITS +: F0_W];
    endfunction

    logic                   issue, retire;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [INFL_W-1:0]      r_inflight, n_inflight;

    logic signed [RX_W-1:0] rx0, rx1, ry0, ry1;

    logic signed [PROD_W-1:0] r1_px [NUM_CORNERS];
    logic signed [PROD_W-1:0] r1_py [NUM_CORNERS];
    logic [T2_W-1:0]          r1_tx2, r1_ty2;
    logic [FRAC_BITS-1:0]     r1_fx, r1_fy;

    logic signed [DOT_W-1:0]  r2_d [NUM_CORNERS];
    logic [F0_W-1:0]          r2_f0x, r2_f0y;
    logic [FRAC_BITS-1:0]     r2_fx, r2_fy;

    logic [M3_W-1:0]          m3x, m3y;
    logic [F1_W-1:0]          r3_f1x, r3_f1y;
    logic [FRAC_BITS-1:0]     r3_fx, r3_fy;
    logic signed [DIFF_W-1:0] r3_dx0, r3_dx1;
    logic signed [DOT_W-1:0]  r3_d00, r3_d01;

    logic [M4_W-1:0]          m4x, m4y;
    logic [F1_W-1:0]          r4_f2x, r4_f2y;
    logic [FRAC_BITS-1:0]     r4_fx, r4_fy;
    logic signed [DIFF_W-1:0] r4_dx0, r4_dx1;
    logic signed [DOT_W-1:0]  r4_d00, r4_d01;

    logic [M4_W-1:0]          m5x, m5y;
    logic [FU_W-1:0]          r5_u, r5_v;
    logic signed [DIFF_W-1:0] r5_dx0, r5_dx1;
    logic signed [DOT_W-1:0]  r5_d00, r5_d01;

    logic signed [LX_W-1:0]   r6_px0, r6_px1;
    logic signed [DOT_W-1:0]  r6_d00, r6_d01;
    logic [FU_W-1:0]          r6_v;

    logic signed [NX_W-1:0]   r7_nx0, r7_nx1;
    logic [FU_W-1:0]          r7_v;

    logic signed [DY_W-1:0]   r8_dy;
    logic signed [NX_W-1:0]   r8_nx0;
    logic [FU_W-1:0]          r8_v;

    logic signed [LY_W-1:0]   r9_py;
    logic signed [NX_W-1:0]   r9_nx0;

    logic signed [NX_W-1:0]   n_sum;
    logic signed [R_W-1:0]    n_scaled;
    logic [NOISE_W-1:0]       n_noise;
    logic [NOISE_W-1:0]       r10_noise;

    // issue only when the result queue has room for everything in flight
    assign issue  = !i_item_empty &&
                    ((SUM_W'(i_out_count) + SUM_W'(r_inflight)) < SUM_W'(OUT_DEPTH));
    assign retire = r_vld[PIPE_STAGES-1];

    assign o_item_pop = issue;
    assign o_out_push = retire;
    assign o_noise    = r10_noise;

    assign o_status.issue    = issue;
    assign o_status.retire   = retire;
    assign o_status.inflight = r_inflight;

    assign n_inflight = r_inflight + INFL_W'(issue) - INFL_W'(retire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_inflight <= '0;
        end else begin
            r_vld      <= {r_vld[PIPE_STAGES-2:0], issue};
            r_inflight <= n_inflight;
        end
    end

    // corner offsets: x - 1.0 is the fraction with the sign bit set
    assign rx0 = $signed({1'b0, i_item.fx});
    assign rx1 = $signed({1'b1, i_item.fx});
    assign ry0 = $signed({1'b0, i_item.fy});
    assign ry1 = $signed({1'b1, i_item.fy});

    assign m3x = M3_W'(r2_f0x) * M3_W'(r2_fx);
    assign m3y = M3_W'(r2_f0y) * M3_W'(r2_fy);
    assign m4x = M4_W'(r3_f1x) * M4_W'(r3_fx);
    assign m4y = M4_W'(r3_f1y) * M4_W'(r3_fy);
    assign m5x = M4_W'(r4_f2x) * M4_W'(r4_fx);
    assign m5y = M4_W'(r4_f2y) * M4_W'(r4_fy);

    always_comb begin
        n_sum    = r9_nx0 + NX_W'(r9_py >>> FRAC_BITS);
        n_scaled = R_W'(n_sum >>> OUT_SHIFT);
        if (n_scaled[R_W-1:NOISE_W-1] != {(R_W - NOISE_W + 1){n_scaled[NOISE_W-1]}}) begin
            n_noise = n_scaled[R_W-1] ? {1'b1, {(NOISE_W-1){1'b0}}}
                                      : {1'b0, {(NOISE_W-1){1'b1}}};
        end else begin
            n_noise = n_scaled[NOISE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        // gradient products and fade squares
        r1_px[0] <= $signed(i_item.gx[0]) * rx0;
        r1_py[0] <= $signed(i_item.gy[0]) * ry0;
        r1_px[1] <= $signed(i_item.gx[1]) * rx1;
        r1_py[1] <= $signed(i_item.gy[1]) * ry0;
        r1_px[2] <= $signed(i_item.gx[2]) * rx0;
        r1_py[2] <= $signed(i_item.gy[2]) * ry1;
        r1_px[3] <= $signed(i_item.gx[3]) * rx1;
        r1_py[3] <= $signed(i_item.gy[3]) * ry1;
        r1_tx2   <= T2_W'(i_item.fx) * T2_W'(i_item.fx);
        r1_ty2   <= T2_W'(i_item.fy) * T2_W'(i_item.fy);
        r1_fx    <= i_item.fx;
        r1_fy    <= i_item.fy;

        // dots and fade polynomial seed
        for (int k = 0; k < NUM_CORNERS; k++) begin
            r2_d[k] <= DOT_W'(r1_px[k]) + DOT_W'(r1_py[k]);
        end
        r2_f0x <= fade_seed(r1_tx2, r1_fx);
        r2_f0y <= fade_seed(r1_ty2, r1_fy);
        r2_fx  <= r1_fx;
        r2_fy  <= r1_fy;

        r3_f1x <= m3x[FRAC_BITS +: F1_W];
        r3_f1y <= m3y[FRAC_BITS +: F1_W];
        r3_fx  <= r2_fx;
        r3_fy  <= r2_fy;
        r3_dx0 <= DIFF_W'(r2_d[1]) - DIFF_W'(r2_d[0]);
        r3_dx1 <= DIFF_W'(r2_d[3]) - DIFF_W'(r2_d[2]);
        r3_d00 <= r2_d[0];
        r3_d01 <= r2_d[2];

        r4_f2x <= m4x[FRAC_BITS +: F1_W];
        r4_f2y <= m4y[FRAC_BITS +: F1_W];
        r4_fx  <= r3_fx;
        r4_fy  <= r3_fy;
        r4_dx0 <= r3_dx0;
        r4_dx1 <= r3_dx1;
        r4_d00 <= r3_d00;
        r4_d01 <= r3_d01;

        r5_u   <= m5x[FRAC_BITS +: FU_W];
        r5_v   <= m5y[FRAC_BITS +: FU_W];
        r5_dx0 <= r4_dx0;
        r5_dx1 <= r4_dx1;
        r5_d00 <= r4_d00;
        r5_d01 <= r4_d01;

        // blend along x
        r6_px0 <= r5_dx0 * $signed({1'b0, r5_u});
        r6_px1 <= r5_dx1 * $signed({1'b0, r5_u});
        r6_d00 <= r5_d00;
        r6_d01 <= r5_d01;
        r6_v   <= r5_v;

        r7_nx0 <= NX_W'(r6_d00) + NX_W'(r6_px0 >>> FRAC_BITS);
        r7_nx1 <= NX_W'(r6_d01) + NX_W'(r6_px1 >>> FRAC_BITS);
        r7_v   <= r6_v;

        // blend along y
        r8_dy  <= DY_W'(r7_nx1) - DY_W'(r7_nx0);
        r8_nx0 <= r7_nx0;
        r8_v   <= r7_v;

        r9_py  <= r8_dy * $signed({1'b0, r8_v});
        r9_nx0 <= r8_nx0;

        r10_noise <= n_noise;
    end

endmodule

/* rtl/perlin_gradient_noise_2d_unit.sv */
// channel   direction  handshake                 payload
// sample    in         push / full               i_sample_x, i_sample_y (s16.16)
// noise     out        empty / pop               o_noise_value (Q2.14, saturated)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data (64 bit)
//
// one sample per cycle sustained while pop keeps pace with the results; a sample passes
// through the sample queue, the ten-stage arithmetic pipeline and the result queue
// reset is synchronous, active low; it restores the permutation and gradient registers
// the pipeline issues only while the 16-entry result queue has room for all in-flight work,
// so a stalled pop fills the result queue, then the sample queue, then raises full
module perlin_gradient_noise_2d_unit #(
    parameter int MID_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [pgn_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [pgn_pkg::SAMPLE_W-1:0] i_sample_y,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [pgn_pkg::NOISE_W-1:0]  o_noise_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pgn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pgn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pgn_pkg::*;

    t_corner_item         front_item, mid_item;
    logic                 mid_empty, mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                 out_push, out_full;
    logic [NOISE_W-1:0]   back_noise, out_noise;
    logic [OUT_CNT_W-1:0] out_count;
    t_back_status         back_status;

    pgn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .o_item      (front_item)
    );

    pgn_queue #(
        .WIDTH ($bits(t_corner_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    pgn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (mid_item),
        .i_item_empty (mid_empty),
        .o_item_pop   (mid_pop),
        .i_out_count  (out_count),
        .o_out_push   (out_push),
        .o_noise      (back_noise),
        .o_status     (back_status)
    );

    pgn_queue #(
        .WIDTH (NOISE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_noise),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_noise),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_noise_value = $signed(out_noise);

`ifndef ASSERT_OFF
    a_no_result_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.retire |-> !out_full)
        else $error("result written into a full result queue");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(back_status.inflight)
            <= (OUT_CNT_W + 1)'(OUT_DEPTH))
        else $error("in-flight transactions exceed result queue space");

    a_mid_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.issue |-> mid_count != '0)
        else $error("pipeline issued from an empty sample queue");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pgn_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd5;
    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
    localparam longint NOISE_MAX = (longint'(1) << (NOISE_W - 1)) - 1;
    localparam longint NOISE_MIN = -(longint'(1) << (NOISE_W - 1));

    typedef struct {
        logic [SAMPLE_W-1:0]       x;
        logic [SAMPLE_W-1:0]       y;
        logic signed [NOISE_W-1:0] noise;
    } t_noise_expect;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic signed [SAMPLE_W-1:0]   i_sample_x = '0;
    logic signed [SAMPLE_W-1:0]   i_sample_y = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic signed [NOISE_W-1:0]    o_noise_value;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    logic [CFG_DATA_W-1:0] perm_copy = PERM_RESET;
    logic [CFG_DATA_W-1:0] gx_lo_copy = '0;
    logic [CFG_DATA_W-1:0] gx_hi_copy = '0;
    logic [CFG_DATA_W-1:0] gy_lo_copy = '0;
    logic [CFG_DATA_W-1:0] gy_hi_copy = '0;

    t_noise_expect noise_expected[$];
    int errors = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 47;

    perlin_gradient_noise_2d_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .empty         (empty),
        .pop           (pop),
        .o_noise_value (o_noise_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LAT_BITS-1:0] perm_entry(input logic [LAT_BITS-1:0] idx);
        return perm_copy[idx * 4 +: LAT_BITS];
    endfunction

    function automatic longint gradient_value(input logic [CFG_DATA_W-1:0] lo,
                                              input logic [CFG_DATA_W-1:0] hi,
                                              input logic [LAT_BITS-1:0] idx);
        logic [CFG_DATA_W-1:0] word;
        logic [GRAD_W-1:0]     b;
        word = idx[LAT_BITS-1] ? hi : lo;
        b = word[idx[LAT_BITS-2:0] * 8 +: GRAD_W] & GRAD_MASK;
        return longint'($signed(b));
    endfunction

    function automatic longint corner_dot(input int cx, input int cy,
                                          input longint rx, input longint ry);
        logic [LAT_BITS-1:0] row_hash;
        logic [LAT_BITS-1:0] lat_idx;
        logic [LAT_BITS-1:0] g;
        row_hash = perm_entry(cy[LAT_BITS-1:0]);
        lat_idx = cx[LAT_BITS-1:0] + row_hash;
        g = perm_entry(lat_idx);
        return gradient_value(gx_lo_copy, gx_hi_copy, g) * rx
             + gradient_value(gy_lo_copy, gy_hi_copy, g) * ry;
    endfunction

    function automatic longint fade_q16(input longint t);
        longint p;
        longint f;
        p = FADE_C6 * t * t - FADE_C15 * t * FRAC_ONE + (longint'(FADE_C10) << 32);
        f = p >>> FRAC_BITS;
        repeat (3) f = (f * t) >>> FRAC_BITS;
        return f;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [NOISE_W-1:0] predict_noise(input logic [SAMPLE_W-1:0] sx,
                                                                input logic [SAMPLE_W-1:0] sy);
        int     x0;
        int     y0;
        longint fx;
        longint fy;
        longint u;
        longint v;
        longint d00;
        longint d10;
        longint d01;
        longint d11;
        longint n;
        x0 = int'($signed(sx[SAMPLE_W-1:FRAC_BITS]));
        y0 = int'($signed(sy[SAMPLE_W-1:FRAC_BITS]));
        fx = longint'(sx[FRAC_BITS-1:0]);
        fy = longint'(sy[FRAC_BITS-1:0]);
        d00 = corner_dot(x0, y0, fx, fy);
        d10 = corner_dot(x0 + 1, y0, fx - FRAC_ONE, fy);
        d01 = corner_dot(x0, y0 + 1, fx, fy - FRAC_ONE);
        d11 = corner_dot(x0 + 1, y0 + 1, fx - FRAC_ONE, fy - FRAC_ONE);
        u = fade_q16(fx);
        v = fade_q16(fy);
        n = blend(blend(d00, d10, u), blend(d01, d11, u), v) >>> OUT_SHIFT;
        if (n > NOISE_MAX) begin
            n = NOISE_MAX;
        end
        if (n < NOISE_MIN) begin
            n = NOISE_MIN;
        end
        return n[NOISE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_coord();
        logic [15:0] whole;
        logic [15:0] frac;
        whole = 16'($urandom);
        frac = 16'($urandom);
        case ($urandom_range(3))
            0: begin
            end
            1: begin
                whole = 16'($urandom_range(31)) - 16'd16;
            end
            2: begin
                case ($urandom_range(3))
                    0: frac = 16'h0000;
                    1: frac = 16'hFFFF;
                    2: frac = 16'h8000;
                    default: frac = 16'h0001;
                endcase
            end
            default: begin
                case ($urandom_range(5))
                    0: whole = 16'h7FFF;
                    1: whole = 16'h8000;
                    2: whole = 16'h7FFE;
                    3: whole = 16'h8001;
                    4: whole = 16'hFFFF;
                    default: whole = 16'h0000;
                endcase
            end
        endcase
        return {whole, frac};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_noise
        t_noise_expect want;
        if (i_rst_n && pop && !empty) begin
            if (noise_expected.size() == 0) begin
                $display("%0t: unexpected noise transaction, expected none, actual %0d",
                         $time, o_noise_value);
                errors++;
            end else begin
                want = noise_expected.pop_front();
                if (o_noise_value !== want.noise) begin
                    $display("%0t: noise mismatch x=%h y=%h, expected %0d, actual %0d",
                             $time, want.x, want.y, want.noise, o_noise_value);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
        t_noise_expect item;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        item.x = x;
        item.y = y;
        item.noise = predict_noise(x, y);
        noise_expected.push_back(item);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (noise_expected.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PERM:  perm_copy  = data;
            CFG_GX_LO: gx_lo_copy = data;
            CFG_GX_HI: gx_hi_copy = data;
            CFG_GY_LO: gy_lo_copy = data;
            CFG_GY_HI: gy_hi_copy = data;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] perm,
                             input logic [CFG_DATA_W-1:0] gx_lo,
                             input logic [CFG_DATA_W-1:0] gx_hi,
                             input logic [CFG_DATA_W-1:0] gy_lo,
                             input logic [CFG_DATA_W-1:0] gy_hi);
        write_register(CFG_PERM, perm);
        write_register(CFG_GX_LO, gx_lo);
        write_register(CFG_GX_HI, gx_hi);
        write_register(CFG_GY_LO, gy_lo);
        write_register(CFG_GY_HI, gy_hi);
    endtask

    // zero gradients after reset give zero noise everywhere
    task automatic test_reset_state();
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(random_coord(), random_coord());
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    // field extremes, negative cells and lattice wrap
    task automatic test_extremes();
        logic [SAMPLE_W-1:0] xs [10];
        logic [SAMPLE_W-1:0] ys [10];
        int k;
        xs = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h0000_FFFF, 32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_8000, 32'h000F_8000};
        ys = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h0000_FFFF, 32'h0000_8000, 32'h0001_8000, 32'h8000_8000, 32'h0010_8000};
        write_all(64'h0123_4567_89AB_CDEF, 64'h807F_807F_807F_807F, 64'h7F80_7F80_7F80_7F80,
                  64'h8080_7F7F_8080_7F7F, 64'h7F7F_8080_7F7F_8080);
        for (k = 0; k < 10; k++) begin
            send_sample(xs[k], ys[k]);
        end
    endtask

    // corner gradients aligned with their offsets for the largest blend of either sign
    task automatic test_peak_blend();
        write_all(64'hFEDC_BA98_7654_7520, 64'h8000_7F00_0080_007F, 64'h0,
                  64'h8000_8000_007F_007F, 64'h0);
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(32'h0000_7FFF, 32'h0000_8001);
        send_sample(32'h0000_4000, 32'h0000_C000);
        send_sample(32'h0010_8000, 32'hFFF0_8000);
        write_all(64'hFEDC_BA98_7654_7520, 64'h7F00_8000_007F_0080, 64'h0,
                  64'h7F00_7F00_0080_0080, 64'h0);
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(32'h0000_8001, 32'h0000_7FFF);
        send_sample(32'h0000_C000, 32'h0000_4000);
        send_sample(32'hFFF0_8000, 32'h0010_8000);
    endtask

    // writes to unmapped indexes leave the registers alone
    task automatic test_unmapped_index();
        int k;
        for (k = CFG_UNMAPPED_FIRST; k < (1 << CFG_IDX_W); k++) begin
            write_register(k[CFG_IDX_W-1:0], random_word());
        end
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(random_coord(), random_coord());
    endtask

    task automatic test_random_phases();
        int phase;
        int k;
        logic [CFG_DATA_W-1:0] perm;
        logic [CFG_DATA_W-1:0] grad [4];
        for (phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            perm = (phase == 1) ? '1 : (phase == 2) ? '0 : random_word();
            for (k = 0; k < 4; k++) begin
                case (phase)
                    1: grad[k] = '1;
                    3: grad[k] = {8{8'h80}};
                    4: grad[k] = {8{8'h7F}};
                    default: grad[k] = random_word();
                endcase
            end
            write_all(perm, grad[0], grad[1], grad[2], grad[3]);
            for (k = 0; k < 280; k++) begin
                if (k == 140) begin
                    wait_drained();
                end
                send_sample(random_coord(), random_coord());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_extremes();
        test_peak_blend();
        test_unmapped_index();
        test_random_phases();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

/* perlin_gradient_noise_2d_unit.f */
rtl/pgn_pkg.sv
rtl/pgn_queue.sv
rtl/pgn_front.sv
rtl/pgn_back.sv
rtl/perlin_gradient_noise_2d_unit.sv
sim/testbench.sv
